FILE: src/dbdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbdr_pkg
// Shared types, codes, reset values and the debounce step for the dual
// button debounce and request block.
// ----------------------------------------------------------------------------
package dbdr_pkg;

    localparam int RUN_W   = 8;
    localparam int HOLD_W  = 16;
    localparam int COOL_W  = 16;
    localparam int DEB_W   = 8;

    localparam int ACTION_W   = 2;
    localparam int IN_BITS    = ACTION_W + 2;
    localparam int OUT_BITS   = 7;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item kinds.
    localparam logic [ACTION_W-1:0] ACT_POLL    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ARM     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISARM  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_POLLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_POLLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_A_PRES  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_COUNT = 8'd3;
    localparam logic [HOLD_W-1:0] RST_HOLD_POLLS     = 16'd200;
    localparam logic [COOL_W-1:0] RST_COOLDOWN_POLLS = 16'd500;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef struct packed {
        logic             stable;
        logic             last;
        logic [RUN_W-1:0] run;
        logic             changed;
    } t_deb;

    // One debounce step: count equal samples, saturating, and move the stable
    // state once the run has reached the configured count.
    function automatic t_deb deb_step(input logic             sample,
                                      input logic             stable,
                                      input logic             last,
                                      input logic [RUN_W-1:0] run,
                                      input logic [DEB_W-1:0] count);
        t_deb res;
        res.last = sample;
        if (sample == last) begin
            res.run = (run == RUN_MAX) ? run : run + 1'b1;
        end else begin
            res.run = {{(RUN_W-1){1'b0}}, 1'b1};
        end
        res.changed = (res.run >= count) && (res.last != stable);
        res.stable  = res.changed ? res.last : stable;
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: src/dual_button_debounce_request_logic_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_button_debounce_request_logic_top
// Debounces two active-low buttons and keeps sticky upload, cancel and format
// requests with an arm flag and a post-disarm cooldown.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[1:0] action, [2] level_a, [3] level_b
//  m_axis    out        tdata[0] a_pressed ... [6] cooldown_active
//  cfg       in         index 0..3 and 16-bit data, always ready
//
//  Every transaction gives one result: the accepting edge loads the input
//  register, and the state is updated into the result register once that
//  register is free. A new item is accepted every cycle while results are
//  taken. The result register stalls the input register when not taken, and
//  the input side stalls only when both are full. Reset is synchronous and
//  returns all state and configuration to their defaults.
// ----------------------------------------------------------------------------
module dual_button_debounce_request_logic_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [1:0] action, [2] level_a, [3] level_b, upper bits zero
    input  wire  [dbdr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [0] a_pressed, [1] b_pressed, [2] upload_request, [3] cancel_request,
    // [4] format_request, [5] armed, [6] cooldown_active, [7] zero
    output logic [dbdr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [dbdr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [dbdr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration.
    logic [dbdr_pkg::DEB_W-1:0]  r_deb_count;
    logic [dbdr_pkg::HOLD_W-1:0] r_hold_polls;
    logic [dbdr_pkg::COOL_W-1:0] r_cool_polls;
    logic                        r_a_present;

    // Input register.
    logic                           r_in_valid;
    logic [dbdr_pkg::ACTION_W-1:0]  r_in_action;
    logic                           r_in_level_a;
    logic                           r_in_level_b;

    // Block state.
    logic                        r_a_stable, r_a_last;
    logic [dbdr_pkg::RUN_W-1:0]  r_a_run;
    logic                        r_b_stable, r_b_last;
    logic [dbdr_pkg::RUN_W-1:0]  r_b_run;
    logic [dbdr_pkg::HOLD_W-1:0] r_hold;
    logic                        r_armed, r_cancel, r_upload, r_format;
    logic [dbdr_pkg::COOL_W-1:0] r_cool;

    logic                        n_a_stable, n_a_last;
    logic [dbdr_pkg::RUN_W-1:0]  n_a_run;
    logic                        n_b_stable, n_b_last;
    logic [dbdr_pkg::RUN_W-1:0]  n_b_run;
    logic [dbdr_pkg::HOLD_W-1:0] n_hold;
    logic                        n_armed, n_cancel, n_upload, n_format;
    logic [dbdr_pkg::COOL_W-1:0] n_cool;

    // Result register.
    logic                        r_out_valid;
    logic [dbdr_pkg::OUT_BITS-1:0] r_out_data;
    logic [dbdr_pkg::OUT_BITS-1:0] n_out_data;

    logic w_out_free;
    logic w_adv;
    logic w_in_take;
    logic w_cfg_take;

    dbdr_pkg::t_deb w_deb_a, w_deb_b;
    logic [dbdr_pkg::HOLD_W-1:0] w_hold_inc;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_cfg_take      = i_cfg_valid && o_cfg_ready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(dbdr_pkg::OUT_DATA_W - dbdr_pkg::OUT_BITS){1'b0}}, r_out_data};

    assign w_deb_a = dbdr_pkg::deb_step(r_in_level_a, r_a_stable, r_a_last, r_a_run,
                                        r_deb_count);
    assign w_deb_b = dbdr_pkg::deb_step(r_in_level_b, r_b_stable, r_b_last, r_b_run,
                                        r_deb_count);
    assign w_hold_inc = r_hold + 1'b1;

    always_comb begin
        n_a_stable = r_a_stable;
        n_a_last   = r_a_last;
        n_a_run    = r_a_run;
        n_b_stable = r_b_stable;
        n_b_last   = r_b_last;
        n_b_run    = r_b_run;
        n_hold     = r_hold;
        n_armed    = r_armed;
        n_cancel   = r_cancel;
        n_upload   = r_upload;
        n_format   = r_format;
        n_cool     = r_cool;
        case (r_in_action)
            dbdr_pkg::ACT_POLL: begin
                if (r_a_present) begin
                    n_a_stable = w_deb_a.stable;
                    n_a_last   = w_deb_a.last;
                    n_a_run    = w_deb_a.run;
                    // A release counts only when no cooldown was running.
                    if (w_deb_a.changed && w_deb_a.stable && (r_cool == '0)) begin
                        if (r_armed) begin
                            n_cancel = 1'b1;
                        end else begin
                            n_upload = 1'b1;
                        end
                    end
                end
                n_b_stable = w_deb_b.stable;
                n_b_last   = w_deb_b.last;
                n_b_run    = w_deb_b.run;
                if (!w_deb_b.stable) begin
                    if (w_hold_inc >= r_hold_polls) begin
                        n_format = 1'b1;
                        n_hold   = '0;
                    end else begin
                        n_hold = w_hold_inc;
                    end
                end else begin
                    n_hold = '0;
                end
                if (r_cool != '0) begin
                    n_cool = r_cool - 1'b1;
                end
            end
            dbdr_pkg::ACT_ARM: begin
                n_armed  = 1'b1;
                n_cancel = 1'b0;
            end
            dbdr_pkg::ACT_DISARM: begin
                n_armed  = 1'b0;
                n_cancel = 1'b0;
                n_upload = 1'b0;
                n_cool   = r_cool_polls;
            end
            dbdr_pkg::ACT_CLEAR: begin
                n_upload = 1'b0;
                n_cancel = 1'b0;
                n_format = 1'b0;
            end
            default: begin
                n_upload = r_upload;
            end
        endcase
        n_out_data = {(n_cool != '0), n_armed, n_format, n_cancel, n_upload,
                      !n_b_stable, r_a_present && !n_a_stable};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_count  <= dbdr_pkg::RST_DEBOUNCE_COUNT;
            r_hold_polls <= dbdr_pkg::RST_HOLD_POLLS;
            r_cool_polls <= dbdr_pkg::RST_COOLDOWN_POLLS;
            r_a_present  <= 1'b1;
        end else if (w_cfg_take) begin
            case (i_cfg_index)
                dbdr_pkg::REG_DEBOUNCE_COUNT: r_deb_count  <= i_cfg_data[dbdr_pkg::DEB_W-1:0];
                dbdr_pkg::REG_HOLD_POLLS:     r_hold_polls <= i_cfg_data;
                dbdr_pkg::REG_COOLDOWN_POLLS: r_cool_polls <= i_cfg_data;
                dbdr_pkg::REG_BUTTON_A_PRES:  r_a_present  <= i_cfg_data[0];
                default:                      r_a_present  <= r_a_present;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action  <= i_s_axis_tdata[dbdr_pkg::ACTION_W-1:0];
            r_in_level_a <= i_s_axis_tdata[dbdr_pkg::ACTION_W];
            r_in_level_b <= i_s_axis_tdata[dbdr_pkg::ACTION_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_stable <= 1'b1;
            r_a_last   <= 1'b1;
            r_a_run    <= '0;
            r_b_stable <= 1'b1;
            r_b_last   <= 1'b1;
            r_b_run    <= '0;
            r_hold     <= '0;
            r_armed    <= 1'b0;
            r_cancel   <= 1'b0;
            r_upload   <= 1'b0;
            r_format   <= 1'b0;
            r_cool     <= '0;
        end else if (w_adv) begin
            r_a_stable <= n_a_stable;
            r_a_last   <= n_a_last;
            r_a_run    <= n_a_run;
            r_b_stable <= n_b_stable;
            r_b_last   <= n_b_last;
            r_b_run    <= n_b_run;
            r_hold     <= n_hold;
            r_armed    <= n_armed;
            r_cancel   <= n_cancel;
            r_upload   <= n_upload;
            r_format   <= n_format;
            r_cool     <= n_cool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // The state moves only when a transaction passes into the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable({r_a_stable, r_a_last, r_a_run, r_b_stable, r_b_last,
                            r_b_run, r_hold, r_armed, r_cancel, r_upload,
                            r_format, r_cool}))
        else $error("state changed without a transaction");

    // A cancel request can only exist while cancel mode is armed.
    a_cancel_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cancel |-> r_armed)
        else $error("cancel request without arm");

    // A format request only appears from a poll.
    a_format_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_format) |-> $past(w_adv && (r_in_action == dbdr_pkg::ACT_POLL)))
        else $error("format request raised outside a poll");

    // A held result is never overwritten by a new one.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_adv)
        else $error("result register overrun");

endmodule
`default_nettype wire
